// File: rtl/core/ffd_pkg.sv
package ffd_pkg;

    // Number of pixels in the canvas
    localparam logic [7:0] NUM_PIXELS = 8'd128;

    // Configuration register indexes
    localparam logic CFG_TOTAL_STEPS = 1'b0;
    localparam logic CFG_MODE        = 1'b1;

    // Item opcodes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Transition modes
    localparam logic MODE_FADE     = 1'b0;
    localparam logic MODE_DISSOLVE = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_QUOTA,
        ST_FADE,
        ST_WRITE
    } ffd_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic div_start;
        logic div_sel_fade;
        logic capture_quota;
        logic commit;
    } ffd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic restart;
        logic active;
        logic frame_start;
        logic fade_mode;
        logic div_done;
    } ffd_stat_t;

endpackage

// File: rtl/core/ffd_ifs.sv
// Input word channel: one canvas byte or a restart
interface ffd_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] target_byte;
    logic [7:0] canvas_byte;
    logic [6:0] pixel_rank;
    logic       frame_last;

    modport source (
        output valid, opcode, target_byte, canvas_byte, pixel_rank, frame_last,
        input  ready
    );
    modport sink (
        input  valid, opcode, target_byte, canvas_byte, pixel_rank, frame_last,
        output ready
    );
endinterface

// Result word channel
interface ffd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] new_byte;
    logic       running;

    modport source (
        output valid, new_byte, running,
        input  ready
    );
    modport sink (
        input  valid, new_byte, running,
        output ready
    );
endinterface

// Configuration write channel
interface ffd_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: rtl/core/frame_fade_dissolve_step.sv
// Frame transition engine for an LED canvas: each input word is a canvas byte
// with its target byte and pixel dissolve rank (or a restart), and each gives
// one result word. Fade moves a byte by (target - current) / remaining steps,
// dissolve swaps in the target for pixels whose rank falls in this step's
// quota window. Words are handled one at a time by a shared 8-bit iterative
// divider that produces one quotient bit per cycle: a restart or a byte after
// the transition has finished goes straight to write-back, a mid-frame fade
// byte or a dissolve frame-start byte makes one pass through the divider, a
// fade byte at frame start makes two (quota and fade step both go through the
// divider), and a mid-frame dissolve byte makes none. The next word is taken
// as soon as the result is in the output register; configuration writes are
// always ready and must only be issued while no word is in flight.
module frame_fade_dissolve_step (
    input  logic        clk,
    input  logic        rst_n,
    ffd_item_if.sink    item,
    ffd_result_if.source result,
    ffd_cfg_if.sink     cfg
);

    ffd_pkg::ffd_cmd_t  cmd;
    ffd_pkg::ffd_stat_t stat;

    assign cfg.ready = 1'b1;

    ffd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .opcode      (item.opcode),
        .target_byte (item.target_byte),
        .canvas_byte (item.canvas_byte),
        .pixel_rank  (item.pixel_rank),
        .frame_last  (item.frame_last),
        .new_byte    (result.new_byte),
        .running     (result.running)
    );

endmodule

// File: rtl/core/ffd_div.sv
// 8-bit unsigned restoring divider, one quotient bit per cycle
module ffd_div (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [7:0] divisor,
    output logic       done,
    output logic [7:0] quotient
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] count_reg, count_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quot_reg, quot_next;
    logic [7:0] dsr_reg, dsr_next;
    logic [8:0] trial;
    logic [8:0] diff;

    // One trial subtraction per cycle
    always_comb
    begin
        trial      = {rem_reg, quot_reg[7]};
        diff       = trial - {1'b0, dsr_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = 3'd0;
            rem_next   = 8'd0;
            quot_next  = dividend;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[8])
            begin
                rem_next  = diff[7:0];
                quot_next = {quot_reg[6:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[7:0];
                quot_next = {quot_reg[6:0], 1'b0};
            end
            count_next = count_reg + 3'd1;
            if (count_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 3'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Operand and result flops
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: rtl/core/ffd_dp.sv
// Datapath: config registers, step state, item holding and result forming
module ffd_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  ffd_pkg::ffd_cmd_t cmd,
    output ffd_pkg::ffd_stat_t stat,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             opcode,
    input  logic [7:0]       target_byte,
    input  logic [7:0]       canvas_byte,
    input  logic [6:0]       pixel_rank,
    input  logic             frame_last,
    output logic [7:0]       new_byte,
    output logic             running
);

    logic [7:0] total_steps_reg, total_steps_next;
    logic       mode_reg, mode_next;
    logic [7:0] step_index_reg, step_index_next;
    logic [7:0] pixels_done_reg, pixels_done_next;
    logic [7:0] step_quota_reg, step_quota_next;
    logic       mid_frame_reg, mid_frame_next;

    logic       op_reg;
    logic [7:0] tgt_reg;
    logic [7:0] cur_reg;
    logic [6:0] rank_reg;
    logic       last_reg;
    logic [7:0] new_byte_reg, new_byte_next;
    logic       running_reg, running_next;

    logic       active;
    logic [7:0] remaining;
    logic [7:0] left;
    logic       neg;
    logic [7:0] magnitude;
    logic [7:0] dividend;
    logic       div_done;
    logic [7:0] quotient;
    logic [8:0] lo;
    logic [8:0] hi;
    logic [8:0] rank_ext;
    logic [8:0] pd_sum;
    logic [7:0] result;

    // Step bookkeeping
    always_comb
    begin
        active    = step_index_reg < total_steps_reg;
        remaining = active ? (total_steps_reg - step_index_reg) : 8'd1;
        left      = (pixels_done_reg < ffd_pkg::NUM_PIXELS)
                  ? (ffd_pkg::NUM_PIXELS - pixels_done_reg) : 8'd0;
        neg       = tgt_reg < cur_reg;
        magnitude = neg ? (cur_reg - tgt_reg) : (tgt_reg - cur_reg);
        dividend  = cmd.div_sel_fade ? magnitude : left;
    end

    ffd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (remaining),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        stat.restart     = (op_reg == ffd_pkg::OP_RESTART);
        stat.active      = active;
        stat.frame_start = !mid_frame_reg;
        stat.fade_mode   = (mode_reg == ffd_pkg::MODE_FADE);
        stat.div_done    = div_done;
    end

    // Result byte
    always_comb
    begin
        lo       = {1'b0, pixels_done_reg};
        hi       = lo + {1'b0, step_quota_reg};
        rank_ext = {2'b00, rank_reg};
        pd_sum   = hi;
        if (!active)
            result = cur_reg;
        else if (mode_reg == ffd_pkg::MODE_FADE)
            result = neg ? (cur_reg - quotient) : (cur_reg + quotient);
        else
            result = (rank_ext >= lo && rank_ext < hi) ? tgt_reg : cur_reg;
    end

    // Next state
    always_comb
    begin
        total_steps_next = total_steps_reg;
        mode_next        = mode_reg;
        step_index_next  = step_index_reg;
        pixels_done_next = pixels_done_reg;
        step_quota_next  = step_quota_reg;
        mid_frame_next   = mid_frame_reg;
        new_byte_next    = new_byte_reg;
        running_next     = running_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                ffd_pkg::CFG_TOTAL_STEPS: total_steps_next = cfg_data;
                ffd_pkg::CFG_MODE:        mode_next        = cfg_data[0];
                default:                  ;
            endcase
        end

        if (cmd.capture_quota)
            step_quota_next = quotient;

        if (cmd.commit)
        begin
            if (op_reg == ffd_pkg::OP_RESTART)
            begin
                step_index_next  = 8'd0;
                pixels_done_next = 8'd0;
                step_quota_next  = 8'd0;
                mid_frame_next   = 1'b0;
                new_byte_next    = 8'd0;
                running_next     = 1'b0;
            end
            else
            begin
                new_byte_next  = result;
                running_next   = active;
                mid_frame_next = !last_reg;
                if (last_reg && active)
                begin
                    step_index_next = step_index_reg + 8'd1;
                    if (mode_reg == ffd_pkg::MODE_DISSOLVE)
                        pixels_done_next = pd_sum[8] ? 8'hFF : pd_sum[7:0];
                end
            end
        end
    end

    // State flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_steps_reg <= 8'd0;
            mode_reg        <= ffd_pkg::MODE_FADE;
            step_index_reg  <= 8'd0;
            pixels_done_reg <= 8'd0;
            step_quota_reg  <= 8'd0;
            mid_frame_reg   <= 1'b0;
        end
        else
        begin
            total_steps_reg <= total_steps_next;
            mode_reg        <= mode_next;
            step_index_reg  <= step_index_next;
            pixels_done_reg <= pixels_done_next;
            step_quota_reg  <= step_quota_next;
            mid_frame_reg   <= mid_frame_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= opcode;
            tgt_reg  <= target_byte;
            cur_reg  <= canvas_byte;
            rank_reg <= pixel_rank;
            last_reg <= frame_last;
        end
        new_byte_reg <= new_byte_next;
        running_reg  <= running_next;
    end

    assign new_byte = new_byte_reg;
    assign running  = running_reg;

endmodule

// File: rtl/core/ffd_ctrl.sv
// Controller: sequences one word through evaluate, divide and write-back
module ffd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ffd_pkg::ffd_stat_t stat,
    output ffd_pkg::ffd_cmd_t  cmd
);

    ffd_pkg::ffd_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffd_pkg::ST_IDLE:
                if (in_valid)
                    state_next = ffd_pkg::ST_EVAL;
            ffd_pkg::ST_EVAL:
                if (stat.restart || !stat.active)
                    state_next = ffd_pkg::ST_WRITE;
                else if (stat.frame_start)
                    state_next = ffd_pkg::ST_QUOTA;
                else if (stat.fade_mode)
                    state_next = ffd_pkg::ST_FADE;
                else
                    state_next = ffd_pkg::ST_WRITE;
            ffd_pkg::ST_QUOTA:
                if (stat.div_done)
                    state_next = stat.fade_mode ? ffd_pkg::ST_FADE : ffd_pkg::ST_WRITE;
            ffd_pkg::ST_FADE:
                if (stat.div_done)
                    state_next = ffd_pkg::ST_WRITE;
            ffd_pkg::ST_WRITE:
                if (slot_free)
                    state_next = ffd_pkg::ST_IDLE;
            default:
                state_next = ffd_pkg::ST_IDLE;
        endcase
    end

    // Commands and handshake
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ffd_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ffd_pkg::ST_EVAL:
                if (!stat.restart && stat.active)
                begin
                    if (stat.frame_start)
                    begin
                        cmd.div_start    = 1'b1;
                        cmd.div_sel_fade = 1'b0;
                    end
                    else if (stat.fade_mode)
                    begin
                        cmd.div_start    = 1'b1;
                        cmd.div_sel_fade = 1'b1;
                    end
                end
            ffd_pkg::ST_QUOTA:
                if (stat.div_done)
                begin
                    cmd.capture_quota = 1'b1;
                    cmd.div_start     = stat.fade_mode;
                    cmd.div_sel_fade  = 1'b1;
                end
            ffd_pkg::ST_FADE:
                cmd.div_sel_fade = 1'b1;
            ffd_pkg::ST_WRITE:
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
